FILE: rtl/mbrtu_pkg.sv
// shared types, constants and the crc step for the modbus rtu request parser
package mbrtu_pkg;

  localparam int unsigned POS_W             = 10;
  localparam int unsigned MAX_FRAME_DEFAULT = 512;

  localparam logic [7:0]  FC_READ_HOLDING   = 8'h03;
  localparam logic [7:0]  FC_WRITE_SINGLE   = 8'h06;
  localparam logic [7:0]  FC_WRITE_MULTIPLE = 8'h10;
  localparam logic [15:0] MAX_READ_COUNT    = 16'd125;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_SHORT  = 3'd1,
    ST_CRC        = 3'd2,
    ST_READ_COUNT = 3'd3,
    ST_BYTE_COUNT = 3'd4,
    ST_WM_LENGTH  = 3'd5,
    ST_OVERLONG   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    FK_UNSUPPORTED = 2'd0,
    FK_READ        = 2'd1,
    FK_WRITE_ONE   = 2'd2,
    FK_WRITE_MANY  = 2'd3
  } fkind_t;

  typedef enum logic {
    RK_DATA    = 1'b0,
    RK_SUMMARY = 1'b1
  } rkind_t;

  typedef struct packed {
    rkind_t      result_kind;
    status_t     status;
    logic [7:0]  slave_address;
    logic [7:0]  function_code;
    fkind_t      function_kind;
    logic [15:0] start_address;
    logic [15:0] register_count;
    logic [15:0] single_value;
    logic [7:0]  byte_cnt;
    logic [15:0] data_word;
    logic [6:0]  data_index;
  } result_t;

  // one byte of the reflected modbus crc
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/mbrtu_if.sv
// valid/ready channels for request bytes and parser results
interface mbrtu_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mbrtu_res_if;
  logic                 valid;
  logic                 ready;
  mbrtu_pkg::rkind_t    result_kind;
  mbrtu_pkg::status_t   status;
  logic [7:0]           slave_address;
  logic [7:0]           function_code;
  mbrtu_pkg::fkind_t    function_kind;
  logic [15:0]          start_address;
  logic [15:0]          register_count;
  logic [15:0]          single_value;
  logic [7:0]           byte_cnt;
  logic [15:0]          data_word;
  logic [6:0]           data_index;

  modport source (output valid, output result_kind, output status, output slave_address,
                  output function_code, output function_kind, output start_address,
                  output register_count, output single_value, output byte_cnt,
                  output data_word, output data_index, input ready);
  modport sink   (input valid, input result_kind, input status, input slave_address,
                  input function_code, input function_kind, input start_address,
                  input register_count, input single_value, input byte_cnt,
                  input data_word, input data_index, output ready);
endinterface

FILE: rtl/modbus_rtu_request_parser.sv
// modbus rtu request parser top level
// Takes one request byte per cycle while req is ready (a transaction on req, frame_end on
// the last byte) and returns results on res. Each byte is decoded in the cycle it is
// accepted: the frame state and a bytewise crc-16 update sit in front of a result register,
// so a byte can be accepted every cycle and the result it causes is registered there. A
// skid register behind the result register keeps req ready while one result waits; req
// stalls only when both hold results. Write-multiple frames produce provisional data word
// results (they may include the crc bytes), and every frame end produces a summary with
// status and decoded fields. Frames longer than MAX_FRAME bytes report overlong.
module modbus_rtu_request_parser #(
  parameter int unsigned MAX_FRAME = mbrtu_pkg::MAX_FRAME_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  mbrtu_req_if.sink      req,
  mbrtu_res_if.source    res
);

  localparam int unsigned POS_W = mbrtu_pkg::POS_W;
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME);
  localparam logic [POS_W-1:0] POS_SAT = {POS_W{1'b1}};

  // frame state
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [15:0]      crc_accumulator, crc_accumulator_next;
  logic [7:0]       tail0, tail0_next;
  logic [7:0]       tail1, tail1_next;
  logic [7:0]       address_byte, address_byte_next;
  logic [7:0]       code_byte, code_byte_next;
  logic [15:0]      start_word, start_word_next;
  logic [15:0]      count_word, count_word_next;
  logic [7:0]       payload_length, payload_length_next;
  logic [7:0]       pending_high_byte, pending_high_byte_next;
  logic             overlong_flag, overlong_flag_next;

  // output and skid registers
  mbrtu_pkg::result_t out_q, skid_q, new_result;
  logic               out_valid, skid_valid, new_valid;

  logic               accept;
  logic               overlong_now;
  logic [15:0]        crc_fed;
  logic [15:0]        rx_crc;
  logic [POS_W-1:0]   data_off;
  mbrtu_pkg::status_t status;
  mbrtu_pkg::fkind_t  kind;

  assign req.ready = !skid_valid;
  assign accept    = req.valid && req.ready;

  always_comb begin
    overlong_now = overlong_flag || (byte_position >= MAX_POS);
    crc_fed = (byte_position >= POS_W'(2)) ? mbrtu_pkg::crc_feed(crc_accumulator, tail1)
                                            : crc_accumulator;
    tail1_next = tail0;
    tail0_next = req.rx_byte;

    address_byte_next   = address_byte;
    code_byte_next      = code_byte;
    start_word_next     = start_word;
    count_word_next     = count_word;
    payload_length_next = payload_length;
    case (byte_position)
      POS_W'(0): address_byte_next   = req.rx_byte;
      POS_W'(1): code_byte_next      = req.rx_byte;
      POS_W'(2): start_word_next     = {req.rx_byte, 8'h00};
      POS_W'(3): start_word_next     = {start_word[15:8], req.rx_byte};
      POS_W'(4): count_word_next     = {req.rx_byte, 8'h00};
      POS_W'(5): count_word_next     = {count_word[15:8], req.rx_byte};
      POS_W'(6): payload_length_next = req.rx_byte;
      default: ;
    endcase

    byte_position_next = (byte_position == POS_SAT) ? byte_position
                                                    : byte_position + POS_W'(1);
    pending_high_byte_next = pending_high_byte;
    new_result = '0;
    new_valid  = 1'b0;
    data_off   = byte_position - POS_W'(7);
    rx_crc     = {tail0_next, tail1_next};
    status     = mbrtu_pkg::ST_OK;
    kind       = mbrtu_pkg::FK_UNSUPPORTED;

    if (!req.frame_end) begin
      if (byte_position >= POS_W'(7) && code_byte == mbrtu_pkg::FC_WRITE_MULTIPLE
          && !overlong_now) begin
        if (!data_off[0]) begin
          pending_high_byte_next = req.rx_byte;
        end else if (data_off < POS_W'(256)) begin
          new_valid              = 1'b1;
          new_result.result_kind = mbrtu_pkg::RK_DATA;
          new_result.data_word   = {pending_high_byte, req.rx_byte};
          new_result.data_index  = data_off[7:1];
        end
      end
    end else begin
      // summary at frame end, checks in precedence order
      case (code_byte_next)
        mbrtu_pkg::FC_READ_HOLDING:   kind = mbrtu_pkg::FK_READ;
        mbrtu_pkg::FC_WRITE_SINGLE:   kind = mbrtu_pkg::FK_WRITE_ONE;
        mbrtu_pkg::FC_WRITE_MULTIPLE: kind = mbrtu_pkg::FK_WRITE_MANY;
        default:                      kind = mbrtu_pkg::FK_UNSUPPORTED;
      endcase
      if (overlong_now) begin
        status = mbrtu_pkg::ST_OVERLONG;
      end else if (byte_position < POS_W'(7)) begin
        status = mbrtu_pkg::ST_TOO_SHORT;
      end else if (rx_crc != crc_fed) begin
        status = mbrtu_pkg::ST_CRC;
      end else if (kind == mbrtu_pkg::FK_READ) begin
        if (count_word_next == 16'd0 || count_word_next > mbrtu_pkg::MAX_READ_COUNT) begin
          status = mbrtu_pkg::ST_READ_COUNT;
        end
      end else if (kind == mbrtu_pkg::FK_WRITE_MANY) begin
        if (byte_position < POS_W'(8)) begin
          status = mbrtu_pkg::ST_WM_LENGTH;
        end else if ({9'd0, payload_length_next} != {count_word_next, 1'b0}) begin
          status = mbrtu_pkg::ST_BYTE_COUNT;
        end else if (byte_position != POS_W'(8) + POS_W'(payload_length_next)) begin
          status = mbrtu_pkg::ST_WM_LENGTH;
        end
      end

      new_valid              = 1'b1;
      new_result.result_kind = mbrtu_pkg::RK_SUMMARY;
      new_result.status      = status;
      if (status == mbrtu_pkg::ST_OK) begin
        new_result.slave_address = address_byte_next;
        new_result.function_code = code_byte_next;
        new_result.function_kind = kind;
        if (kind != mbrtu_pkg::FK_UNSUPPORTED) begin
          new_result.start_address = start_word_next;
        end
        if (kind == mbrtu_pkg::FK_READ || kind == mbrtu_pkg::FK_WRITE_MANY) begin
          new_result.register_count = count_word_next;
        end
        if (kind == mbrtu_pkg::FK_WRITE_ONE) begin
          new_result.single_value = count_word_next;
        end
        if (kind == mbrtu_pkg::FK_WRITE_MANY) begin
          new_result.byte_cnt = payload_length_next;
        end
      end
    end

    crc_accumulator_next = crc_fed;
    overlong_flag_next   = overlong_now;
    // frame end puts the frame state back to its reset values
    if (req.frame_end) begin
      byte_position_next     = '0;
      crc_accumulator_next   = mbrtu_pkg::CRC_INIT;
      tail0_next             = '0;
      tail1_next             = '0;
      address_byte_next      = '0;
      code_byte_next         = '0;
      start_word_next        = '0;
      count_word_next        = '0;
      payload_length_next    = '0;
      pending_high_byte_next = '0;
      overlong_flag_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      crc_accumulator   <= mbrtu_pkg::CRC_INIT;
      tail0             <= '0;
      tail1             <= '0;
      address_byte      <= '0;
      code_byte         <= '0;
      start_word        <= '0;
      count_word        <= '0;
      payload_length    <= '0;
      pending_high_byte <= '0;
      overlong_flag     <= 1'b0;
    end else if (accept) begin
      byte_position     <= byte_position_next;
      crc_accumulator   <= crc_accumulator_next;
      tail0             <= tail0_next;
      tail1             <= tail1_next;
      address_byte      <= address_byte_next;
      code_byte         <= code_byte_next;
      start_word        <= start_word_next;
      count_word        <= count_word_next;
      payload_length    <= payload_length_next;
      pending_high_byte <= pending_high_byte_next;
      overlong_flag     <= overlong_flag_next;
    end
  end

  // result register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || res.ready) begin
      if (skid_valid) begin
        out_q      <= skid_q;
        skid_valid <= 1'b0;
      end else if (accept && new_valid) begin
        out_q     <= new_result;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (accept && new_valid) begin
      skid_q     <= new_result;
      skid_valid <= 1'b1;
    end
  end

  assign res.valid          = out_valid;
  assign res.result_kind    = out_q.result_kind;
  assign res.status         = out_q.status;
  assign res.slave_address  = out_q.slave_address;
  assign res.function_code  = out_q.function_code;
  assign res.function_kind  = out_q.function_kind;
  assign res.start_address  = out_q.start_address;
  assign res.register_count = out_q.register_count;
  assign res.single_value   = out_q.single_value;
  assign res.byte_cnt       = out_q.byte_cnt;
  assign res.data_word      = out_q.data_word;
  assign res.data_index     = out_q.data_index;

endmodule

FILE: tb/sv/mbrtu_tb_pkg.sv
// scoreboard for the modbus rtu request parser: frame predictor and result checker
package mbrtu_tb_pkg;
  import mbrtu_pkg::*;

  class request_scoreboard;
    int unsigned max_frame;
    int unsigned byte_pos;
    logic [15:0] crc_acc;
    logic [7:0]  tail [2];
    logic [7:0]  addr_b;
    logic [7:0]  code_b;
    logic [7:0]  bc_b;
    logic [7:0]  high_b;
    logic [15:0] start_w;
    logic [15:0] count_w;
    bit          overlong;
    result_t     pending_results [$];
    int          errors;

    function new(int unsigned frame_limit);
      max_frame = frame_limit;
      errors = 0;
      restart_frame();
    endfunction

    static function logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] v;
      v = c ^ {8'h00, b};
      repeat (8) v = (v >> 1) ^ (v[0] ? CRC_POLY : 16'h0000);
      return v;
    endfunction

    function void restart_frame();
      byte_pos = 0;
      crc_acc = CRC_INIT;
      tail[0] = '0;
      tail[1] = '0;
      addr_b = '0;
      code_b = '0;
      bc_b = '0;
      high_b = '0;
      start_w = '0;
      count_w = '0;
      overlong = 0;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    // accepted request byte: advance the frame state, queue what it causes
    function void take_byte(logic [7:0] b, bit last);
      int unsigned p;
      int unsigned off;
      int unsigned len;
      result_t     r;
      logic [15:0] rx_crc;
      fkind_t      kind;
      p = byte_pos;
      r = '0;
      if (p >= max_frame) overlong = 1;
      // the two newest bytes stay out of the crc until they are known not to be the crc
      if (p >= 2) crc_acc = crc16_step(crc_acc, tail[1]);
      tail[1] = tail[0];
      tail[0] = b;
      case (p)
        0: addr_b = b;
        1: code_b = b;
        2: start_w = {b, 8'h00};
        3: start_w[7:0] = b;
        4: count_w = {b, 8'h00};
        5: count_w[7:0] = b;
        6: bc_b = b;
        default: ;
      endcase
      if (byte_pos < 1023) byte_pos++;

      if (!last) begin
        if (p >= 7 && code_b == FC_WRITE_MULTIPLE && !overlong) begin
          off = p - 7;
          if (off % 2 == 0) begin
            high_b = b;
          end else if ((off >> 1) < 128) begin
            r.result_kind = RK_DATA;
            r.data_word = {high_b, b};
            r.data_index = 7'(off >> 1);
            pending_results.push_back(r);
          end
        end
        return;
      end

      len = p + 1;
      rx_crc = {tail[0], tail[1]};
      kind = FK_UNSUPPORTED;
      r.result_kind = RK_SUMMARY;
      r.status = ST_OK;
      if (overlong) begin
        r.status = ST_OVERLONG;
      end else if (len < 8) begin
        r.status = ST_TOO_SHORT;
      end else if (rx_crc != crc_acc) begin
        r.status = ST_CRC;
      end else if (code_b == FC_READ_HOLDING) begin
        kind = FK_READ;
        if (count_w == 0 || count_w > MAX_READ_COUNT) r.status = ST_READ_COUNT;
      end else if (code_b == FC_WRITE_SINGLE) begin
        kind = FK_WRITE_ONE;
      end else if (code_b == FC_WRITE_MULTIPLE) begin
        kind = FK_WRITE_MANY;
        if (len < 9) r.status = ST_WM_LENGTH;
        else if (int'(bc_b) != 2 * int'(count_w)) r.status = ST_BYTE_COUNT;
        else if (len != 9 + int'(bc_b)) r.status = ST_WM_LENGTH;
      end
      if (r.status == ST_OK) begin
        r.slave_address = addr_b;
        r.function_code = code_b;
        r.function_kind = kind;
        if (kind != FK_UNSUPPORTED) r.start_address = start_w;
        if (kind == FK_READ || kind == FK_WRITE_MANY) r.register_count = count_w;
        if (kind == FK_WRITE_ONE) r.single_value = count_w;
        if (kind == FK_WRITE_MANY) r.byte_cnt = bc_b;
      end
      pending_results.push_back(r);
      restart_frame();
    endfunction

    function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      cmp_field("result_kind", want.result_kind, got.result_kind);
      cmp_field("status", want.status, got.status);
      cmp_field("slave_address", want.slave_address, got.slave_address);
      cmp_field("function_code", want.function_code, got.function_code);
      cmp_field("function_kind", want.function_kind, got.function_kind);
      cmp_field("start_address", want.start_address, got.start_address);
      cmp_field("register_count", want.register_count, got.register_count);
      cmp_field("single_value", want.single_value, got.single_value);
      cmp_field("byte_cnt", want.byte_cnt, got.byte_cnt);
      cmp_field("data_word", want.data_word, got.data_word);
      cmp_field("data_index", want.data_index, got.data_index);
    endfunction
  endclass

endpackage

FILE: tb/sv/tb_top.sv
// top level testbench for the modbus rtu request parser
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mbrtu_pkg::*;
  import mbrtu_tb_pkg::*;

  localparam int unsigned LIMIT = 200000;

  logic clk;
  logic rst;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  bit tx_steady = 0;
  logic [7:0] frame_bytes [$];

  mbrtu_req_if req_ch();
  mbrtu_res_if res_ch();

  modbus_rtu_request_parser u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  request_scoreboard sb = new(MAX_FRAME_DEFAULT);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin : mon
    result_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.result_kind = res_ch.result_kind;
      got.status = res_ch.status;
      got.slave_address = res_ch.slave_address;
      got.function_code = res_ch.function_code;
      got.function_kind = res_ch.function_kind;
      got.start_address = res_ch.start_address;
      got.register_count = res_ch.register_count;
      got.single_value = res_ch.single_value;
      got.byte_cnt = res_ch.byte_cnt;
      got.data_word = res_ch.data_word;
      got.data_index = res_ch.data_index;
      sb.check_result(got);
    end
  end

  // result receiver, with random stalls and a couple of long hold-offs
  initial begin
    int stall;
    int taken;
    bit steady;
    res_ch.ready = 1'b0;
    taken = 0;
    steady = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (taken % 16 == 0) steady = ($urandom_range(0, 3) == 0);
      if (taken == 20 || taken == 60) stall = 300;
      else stall = steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
      taken++;
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit last);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.rx_byte <= b;
    req_ch.frame_end <= last;
    do @(posedge clk); while (!req_ch.ready);
    sb.take_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    tx_steady = ($urandom_range(0, 3) == 0);
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic pause_until_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() > 0);
  endtask

  function automatic void open_frame(logic [7:0] a, logic [7:0] fc);
    frame_bytes.delete();
    frame_bytes.push_back(a);
    frame_bytes.push_back(fc);
  endfunction

  function automatic void put_word(logic [15:0] w);
    frame_bytes.push_back(w[15:8]);
    frame_bytes.push_back(w[7:0]);
  endfunction

  function automatic void put_random(int n);
    repeat (n) frame_bytes.push_back(8'($urandom));
  endfunction

  // crc goes out low byte first
  function automatic void seal_frame();
    logic [15:0] c;
    c = CRC_INIT;
    foreach (frame_bytes[i]) c = request_scoreboard::crc16_step(c, frame_bytes[i]);
    frame_bytes.push_back(c[7:0]);
    frame_bytes.push_back(c[15:8]);
  endfunction

  function automatic void make_read(logic [7:0] a, logic [15:0] s, logic [15:0] n);
    open_frame(a, FC_READ_HOLDING);
    put_word(s);
    put_word(n);
    seal_frame();
  endfunction

  function automatic void make_write_one(logic [7:0] a, logic [15:0] s, logic [15:0] v);
    open_frame(a, FC_WRITE_SINGLE);
    put_word(s);
    put_word(v);
    seal_frame();
  endfunction

  function automatic void make_write_many(logic [7:0] a, logic [15:0] s, logic [15:0] n,
                                          logic [7:0] bc, int n_data);
    open_frame(a, FC_WRITE_MULTIPLE);
    put_word(s);
    put_word(n);
    frame_bytes.push_back(bc);
    put_random(n_data);
    seal_frame();
  endfunction

  function automatic void make_other(logic [7:0] a, logic [7:0] fc, int n_body);
    open_frame(a, fc);
    put_random(n_body);
    seal_frame();
  endfunction

  function automatic void make_noise(int n);
    frame_bytes.delete();
    put_random(n);
  endfunction

  function automatic void flip_one_bit();
    int k;
    k = $urandom_range(0, frame_bytes.size() - 1);
    frame_bytes[k] = frame_bytes[k] ^ (8'h01 << $urandom_range(0, 7));
  endfunction

  function automatic logic [7:0] odd_code();
    logic [7:0] fc;
    do fc = 8'($urandom);
    while (fc == FC_READ_HOLDING || fc == FC_WRITE_SINGLE || fc == FC_WRITE_MULTIPLE);
    return fc;
  endfunction

  task automatic directed_frames();
    make_read(8'h00, 16'h0000, 16'd1);                 send_frame();
    make_read(8'hFF, 16'hFFFF, MAX_READ_COUNT);        send_frame();
    make_read(8'h01, 16'h1234, 16'd0);                 send_frame();
    make_read(8'h01, 16'h1234, 16'd126);               send_frame();
    make_read(8'h01, 16'h1234, 16'hFFFF);              send_frame();
    make_write_one(8'h02, 16'h0000, 16'h0000);         send_frame();
    make_write_one(8'hFF, 16'hFFFF, 16'hFFFF);         send_frame();
    // zero-count write multiple is accepted
    make_write_many(8'h11, 16'h0010, 16'd0, 8'd0, 0);  send_frame();
    make_write_many(8'h11, 16'h0020, 16'd2, 8'd4, 4);  send_frame();
    make_write_many(8'h11, 16'hFFFF, 16'd20, 8'd40, 40); send_frame();
    make_write_many(8'h11, 16'h0000, 16'd3, 8'd7, 6);  send_frame();
    make_write_many(8'h11, 16'h0000, 16'd3, 8'd6, 7);  send_frame();
    // write multiple with nothing past the count word
    open_frame(8'h11, FC_WRITE_MULTIPLE);
    put_word(16'h0001);
    put_word(16'h0001);
    seal_frame();                                      send_frame();
    make_other(8'h20, 8'h01, 4);                       send_frame();
    make_read(8'h05, 16'h0100, 16'd10);
    flip_one_bit();                                    send_frame();
    make_noise(1);                                     send_frame();
    make_noise(7);                                     send_frame();
    // one byte past the frame limit
    make_other(8'h21, 8'h2B, 509);                     send_frame();
  endtask

  task automatic random_frames();
    int pick;
    int n;
    bit drained;
    int unsigned first_byte;
    logic [15:0] cnt;
    logic [7:0] a;
    first_byte = bytes_sent;
    drained = 0;
    while (bytes_sent - first_byte < 250) begin
      if (!drained && bytes_sent - first_byte >= 125) begin
        pause_until_drained();
        drained = 1;
      end
      pick = $urandom_range(0, 99);
      a = 8'($urandom);
      if (pick < 20) begin
        case ($urandom_range(0, 7))
          0: cnt = 16'd0;
          1: cnt = 16'($urandom_range(126, 65535));
          default: cnt = 16'($urandom_range(1, 125));
        endcase
        make_read(a, 16'($urandom), cnt);
      end else if (pick < 35) begin
        make_write_one(a, 16'($urandom), 16'($urandom));
      end else if (pick < 65) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 127) : $urandom_range(0, 6);
        make_write_many(a, 16'($urandom), 16'(n), 8'(2 * n), 2 * n);
      end else if (pick < 73) begin
        n = $urandom_range(1, 6);
        case ($urandom_range(0, 2))
          0: make_write_many(a, 16'($urandom), 16'(n), 8'(2 * n + 1), 2 * n + 1);
          1: make_write_many(a, 16'($urandom), 16'(n), 8'(2 * n),
                             2 * n + ($urandom_range(0, 1) ? 1 : -1));
          default: begin
            open_frame(a, FC_WRITE_MULTIPLE);
            put_word(16'($urandom));
            put_word(16'($urandom));
            seal_frame();
          end
        endcase
      end else if (pick < 80) begin
        make_other(a, odd_code(), $urandom_range(0, 12));
      end else if (pick < 88) begin
        make_write_many(a, 16'($urandom), 16'd2, 8'd4, 4);
        flip_one_bit();
      end else if (pick < 94) begin
        make_noise($urandom_range(1, 7));
      end else begin
        make_noise($urandom_range(1, 24));
        if (frame_bytes.size() > 1 && $urandom_range(0, 1)) frame_bytes[1] = FC_WRITE_MULTIPLE;
      end
      send_frame();
    end
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.rx_byte = 8'h00;
    req_ch.frame_end = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_frames();
    random_frames();
    req_ch.valid <= 1'b0;
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
